[rtl/ldbic_pkg.sv]
// shared types, constants and helper functions of the lamp dimmer controller
`default_nettype none
package ldbic_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_HALF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_UP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_DOWN  = 3'd5;

  // configuration reset values
  localparam logic [15:0] RST_DEBOUNCE   = 16'd100;
  localparam logic [15:0] RST_LONG_PRESS = 16'd1000;
  localparam logic [31:0] RST_CODE_HALF  = 32'h01FE50AF;
  localparam logic [31:0] RST_CODE_OFF   = 32'h01FEF807;
  localparam logic [31:0] RST_CODE_UP    = 32'h01FEE01F;
  localparam logic [31:0] RST_CODE_DOWN  = 32'h01FE906F;

  localparam logic [6:0] LEVEL_FULL = 7'd100;
  localparam logic [6:0] LEVEL_HALF = 7'd50;
  localparam logic [6:0] LEVEL_STEP = 7'd10;
  localparam logic [6:0] LEVEL_ZERO = 7'd0;

  // level*255/100 as one constant multiply: floor(x*1336965 / 2^19)
  localparam logic [27:0] DUTY_MUL = 28'd1336965;

  typedef enum logic [1:0] {
    OP_IR         = 2'd0,
    OP_BUTTON     = 2'd1,
    OP_REMOTE_ON  = 2'd2,
    OP_REMOTE_OFF = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SHORT   = 2'd1,
    KIND_LONG    = 2'd2,
    KIND_RELEASE = 2'd3
  } press_kind_t;

  typedef enum logic [1:0] {
    MODE_SECOND = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_BOTH   = 2'd2,
    MODE_NONE   = 2'd3
  } out_mode_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [31:0] code_half;
    logic [31:0] code_off;
    logic [31:0] code_up;
    logic [31:0] code_down;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  level;
    logic [2:0]  press_step;
    out_mode_t   mode;
    logic [31:0] last_edge_time;
    logic [31:0] press_start_time;
    logic        press_pending;
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] ir_code;
    logic        button_level;
    logic [31:0] time_ms;
    logic        has_level;
    logic [7:0]  level_value;
  } item_t;

  typedef struct packed {
    logic [6:0]  brightness;
    out_mode_t   output_mode;
    logic [7:0]  duty_first;
    logic [7:0]  duty_second;
    press_kind_t press_kind;
  } result_t;

  function automatic logic [7:0] scale_duty(input logic [6:0] lv);
    logic [27:0] prod;
    prod = {21'd0, lv} * DUTY_MUL;
    return prod[26:19];
  endfunction

  function automatic out_mode_t next_mode(input out_mode_t m);
    out_mode_t r;
    case (m)
      MODE_SECOND: r = MODE_FIRST;
      MODE_FIRST:  r = MODE_BOTH;
      MODE_BOTH:   r = MODE_SECOND;
      default:     r = MODE_FIRST;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ldbic_step.sv]
// next state and result of one event, given the current state and configuration
`default_nettype none
module ldbic_step
  import ldbic_pkg::*;
(
  input  var cfg_t    cfg,
  input  var state_t  cur,
  input  var item_t   item,
  output var state_t  nxt,
  output var result_t res
);

  logic [31:0] since_edge;
  logic [31:0] held;
  logic        held_long;
  logic [7:0]  level_up;
  logic [7:0]  duty;
  logic [2:0]  step_inc;
  press_kind_t kind;

  assign since_edge = item.time_ms - cur.last_edge_time;
  assign held       = item.time_ms - cur.press_start_time;
  assign held_long  = held >= {16'd0, cfg.long_press_ms};
  assign level_up   = {1'b0, cur.level} + {1'b0, LEVEL_STEP};
  assign step_inc   = cur.press_step + 3'd1;

  always_comb begin
    nxt  = cur;
    kind = KIND_NONE;
    case (item.opcode)
      OP_IR: begin
        // first match wins: half, off, up, down
        if (item.ir_code == cfg.code_half) begin
          nxt.level = LEVEL_HALF;
        end else if (item.ir_code == cfg.code_off) begin
          nxt.level = LEVEL_ZERO;
        end else if (item.ir_code == cfg.code_up) begin
          nxt.level = (level_up >= {1'b0, LEVEL_FULL}) ? LEVEL_FULL : level_up[6:0];
        end else if (item.ir_code == cfg.code_down) begin
          nxt.level = (cur.level <= LEVEL_STEP) ? LEVEL_ZERO : cur.level - LEVEL_STEP;
        end
      end
      OP_BUTTON: begin
        if (since_edge >= {16'd0, cfg.debounce_ms}) begin
          nxt.last_edge_time = item.time_ms;
          if (!item.button_level) begin
            if (!cur.press_pending) begin
              nxt.press_start_time = item.time_ms;
              nxt.press_pending    = 1'b1;
            end else if (held_long) begin
              kind              = KIND_LONG;
              nxt.press_pending = 1'b0;
            end
          end else begin
            nxt.press_pending = 1'b0;
            if (!cur.press_pending) begin
              kind = KIND_RELEASE;
            end else if (!held_long) begin
              kind           = KIND_SHORT;
              nxt.press_step = step_inc;
              case (step_inc)
                3'd1: nxt.level = 7'd25;
                3'd2: nxt.level = 7'd33;
                3'd3: nxt.level = LEVEL_HALF;
                3'd4: nxt.level = LEVEL_FULL;
                default: begin
                  // wrap of the press cycle: off and next mode
                  nxt.level      = LEVEL_ZERO;
                  nxt.press_step = 3'd0;
                  nxt.mode       = next_mode(cur.mode);
                end
              endcase
            end
          end
        end
      end
      OP_REMOTE_ON: begin
        if (item.has_level) begin
          nxt.level = (item.level_value > {1'b0, LEVEL_FULL}) ? LEVEL_FULL
                                                              : item.level_value[6:0];
        end else begin
          nxt.level = LEVEL_HALF;
        end
      end
      default: begin
        nxt.level = LEVEL_ZERO;
        nxt.mode  = next_mode(cur.mode);
      end
    endcase
  end

  assign duty = scale_duty(nxt.level);

  always_comb begin
    res.brightness  = nxt.level;
    res.output_mode = nxt.mode;
    res.press_kind  = kind;
    res.duty_first  = 8'd0;
    res.duty_second = 8'd0;
    case (nxt.mode)
      MODE_SECOND: res.duty_second = duty;
      MODE_FIRST:  res.duty_first  = duty;
      MODE_BOTH: begin
        res.duty_first  = duty;
        res.duty_second = duty;
      end
      default: begin
        res.duty_first  = 8'd0;
        res.duty_second = 8'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/lamp_dimmer_button_ir_controller_top.sv]
// top level of the lamp dimmer controller: input register, state, result register
//
//  channel | direction | handshake             | payload
//  in_     | in        | in_valid / in_ready   | opcode, ir_code, button_level, time_ms,
//          |           |                       | has_level, level_value
//  out_    | out       | out_valid / out_ready | brightness, output_mode, duty_first,
//          |           |                       | duty_second, press_kind
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index (3 bit), cfg_data (32 bit)
//
// one item per cycle sustained while out_ready is high; out_valid rises once the
// accepted item has passed the input register, the state update and result register
// in_ready stays high while the input register is empty or moves on, so a waiting
// result does not block the next item until both registers are full
// cfg_ready is always high; reset restores state to zero and configuration registers to defaults
`default_nettype none
module lamp_dimmer_button_ir_controller_top
  import ldbic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output wire logic                  in_ready,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [31:0]           in_ir_code,
  input  wire logic                  in_button_level,
  input  wire logic [31:0]           in_time_ms,
  input  wire logic                  in_has_level,
  input  wire logic [7:0]            in_level_value,

  output wire logic                  out_valid,
  input  wire logic                  out_ready,
  output wire logic [6:0]            out_brightness,
  output wire logic [1:0]            out_output_mode,
  output wire logic [7:0]            out_duty_first,
  output wire logic [7:0]            out_duty_second,
  output wire logic [1:0]            out_press_kind,

  input  wire logic                  cfg_valid,
  output wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  logic    item_v_r;
  result_t res_r;
  result_t res_nxt;
  logic    res_v_r;
  logic    advance;

  assign advance   = item_v_r && (!res_v_r || out_ready);
  assign in_ready  = !item_v_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= RST_DEBOUNCE;
      cfg_r.long_press_ms <= RST_LONG_PRESS;
      cfg_r.code_half     <= RST_CODE_HALF;
      cfg_r.code_off      <= RST_CODE_OFF;
      cfg_r.code_up       <= RST_CODE_UP;
      cfg_r.code_down     <= RST_CODE_DOWN;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce_ms   <= cfg_data[15:0];
        CFG_LONG_PRESS: cfg_r.long_press_ms <= cfg_data[15:0];
        CFG_CODE_HALF:  cfg_r.code_half     <= cfg_data;
        CFG_CODE_OFF:   cfg_r.code_off      <= cfg_data;
        CFG_CODE_UP:    cfg_r.code_up       <= cfg_data;
        CFG_CODE_DOWN:  cfg_r.code_down     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode       <= op_t'(in_opcode);
      item_r.ir_code      <= in_ir_code;
      item_r.button_level <= in_button_level;
      item_r.time_ms      <= in_time_ms;
      item_r.has_level    <= in_has_level;
      item_r.level_value  <= in_level_value;
    end
  end

  ldbic_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        res_v_r <= 1'b1;
      end else if (out_ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_v_r;
  assign out_brightness  = res_r.brightness;
  assign out_output_mode = res_r.output_mode;
  assign out_duty_first  = res_r.duty_first;
  assign out_duty_second = res_r.duty_second;
  assign out_press_kind  = res_r.press_kind;

endmodule
`default_nettype wire
